// ===== hdl/dmx_channel_merge_engine_defines.svh =====
// assertion macros used by the merge engine controller
`ifndef DMX_CHANNEL_MERGE_ENGINE_DEFINES_SVH
`define DMX_CHANNEL_MERGE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define DMX_ASSERT_NOW(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("merge engine check failed");
`define DMX_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("merge engine check failed");
`else
`define DMX_ASSERT_NOW(lbl, clk, rst_n, ant, cons)
`define DMX_ASSERT_NEXT(lbl, clk, rst_n, ant, cons)
`endif
`endif

// ===== hdl/dmx_pkg.sv =====
// shared types, codes and helpers of the dmx channel merge engine
`default_nettype none
package dmx_pkg;
  localparam int CHANNELS_DEF = 512;

  localparam logic [3:0] OP_WRITE = 4'd0;
  localparam logic [3:0] OP_REL   = 4'd1;
  localparam logic [3:0] OP_MASK  = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_CAP   = 4'd5;
  localparam logic [3:0] OP_PASS  = 4'd6;
  localparam logic [3:0] OP_CLEAR = 4'd7;

  localparam logic [7:0] CFG_LEVEL = 8'd0;
  localparam logic [7:0] CFG_SCOPE = 8'd1;
  localparam logic [7:0] CFG_STYLE = 8'd2;
  localparam logic [7:0] CFG_PASS  = 8'd3;

  localparam logic [15:0] REL_CENTER = 16'd127;

  typedef struct packed {
    logic [7:0]  pt;
    logic [1:0]  flags;   // bit0 htp, bit1 intensity
    logic [15:0] off;
    logic [7:0]  base;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr_step;
    logic take;
    logic prod;
    logic upd;
    logic scl;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  // exact floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/dmx_ram.sv =====
// generic single write, single read ram with registered read
`default_nettype none
module dmx_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata_r
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dmx_dp.sv =====
// datapath: channel store, update arithmetic, master and merge, output register
`default_nettype none
module dmx_dp import dmx_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [23:0] in_tdata,
  input  wire logic [3:0]  in_tuser,
  input  wire logic        cfg_valid,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic      [31:0] out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);
  logic [7:0] ml_r, ml_nxt;
  logic scope_r, scope_nxt, style_r, style_nxt, pon_r, pon_nxt;

  logic [3:0] op_r;
  logic [8:0] ch_r;
  logic [7:0] lv_r;
  logic force_r, chtp_r, cint_r, ok_r;
  logic in_ok;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [9:0] used_r, used_nxt;

  entry_t rd_e, new_e;
  logic [ENTRY_W-1:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [ENTRY_W-1:0] wdata;

  logic [15:0] prod_r;
  logic touch, rej;
  logic signed [17:0] sum;
  logic [7:0] v;
  logic [7:0] v_r, pt_r;
  logic cover_r, acc_r;
  logic [15:0] mprod_r;
  logic [7:0] lim, scl, u;
  logic [8:0] addsum;

  logic [31:0] out_r;
  logic out_valid_r, out_valid_nxt;

  // configuration registers
  always_comb begin
    ml_nxt = ml_r;
    scope_nxt = scope_r;
    style_nxt = style_r;
    pon_nxt = pon_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL: ml_nxt = cfg_data;
        CFG_SCOPE: scope_nxt = cfg_data[0];
        CFG_STYLE: style_nxt = cfg_data[0];
        CFG_PASS:  pon_nxt = cfg_data[0];
        default:   ml_nxt = ml_r;
      endcase
    end
  end

  assign in_ok = 32'(in_tdata[8:0]) < CHANNELS;

  // store: one row per channel
  assign we    = cmd.clr_step | (cmd.upd & ok_r);
  assign waddr = cmd.clr_step ? clr_r : AW'(ch_r);
  assign wdata = cmd.clr_step ? '0 : new_e;

  dmx_ram #(.W(ENTRY_W), .D(CHANNELS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(cmd.take), .raddr(AW'(in_tdata[8:0])), .rdata_r(rdata)
  );
  assign rd_e = entry_t'(rdata);

  assign clr_nxt = cmd.clr_step ? clr_r + AW'(1) : clr_r;

  // operation on the row
  always_comb begin
    new_e = rd_e;
    touch = 1'b0;
    rej = 1'b0;
    addsum = {1'b0, rd_e.base} + {1'b0, lv_r};
    case (op_r)
      OP_WRITE: begin
        touch = 1'b1;
        rej = !force_r && rd_e.flags[0] && (lv_r < rd_e.base);
        if (!rej) new_e.base = lv_r;
      end
      OP_REL: begin
        touch = 1'b1;
        new_e.off = rd_e.off + {8'd0, lv_r} - REL_CENTER;
      end
      OP_MASK: begin
        touch = 1'b1;
        new_e.base = div255(prod_r);
      end
      OP_ADD: begin
        touch = 1'b1;
        new_e.base = addsum[8] ? 8'd255 : addsum[7:0];
      end
      OP_SUB: begin
        touch = 1'b1;
        new_e.base = (lv_r >= rd_e.base) ? 8'd0 : rd_e.base - lv_r;
      end
      OP_CAP: new_e.flags = {chtp_r & cint_r, chtp_r};
      OP_PASS: begin
        if (pon_r) begin
          touch = 1'b1;
          new_e.pt = lv_r;
        end
      end
      OP_CLEAR: begin
        new_e.base = 8'd0;
        new_e.off = 16'd0;
      end
      default: new_e = rd_e;
    endcase
    sum = $signed({10'd0, new_e.base}) + $signed({{2{new_e.off[15]}}, new_e.off});
    if (sum < 0) v = 8'd0;
    else if (sum > 18'sd255) v = 8'd255;
    else v = sum[7:0];
  end

  always_comb begin
    used_nxt = used_r;
    if (cmd.upd && ok_r && touch && ({1'b0, ch_r} >= used_r)) begin
      used_nxt = {1'b0, ch_r} + 10'd1;
    end
  end

  // master and passthrough merge
  always_comb begin
    lim = (v_r < ml_r) ? v_r : ml_r;
    scl = div255(mprod_r);
    if (cover_r) u = style_r ? scl : lim;
    else u = v_r;
    if (pon_r && (u < pt_r)) u = pt_r;
    if (!ok_r) u = 8'd0;
  end

  assign out_valid_nxt = cmd.fin ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign sts = '{clr_last: (clr_r == AW'(CHANNELS - 1)),
                 out_free: (!out_valid_r || out_tready)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ml_r <= 8'd255;
      scope_r <= 1'b0;
      style_r <= 1'b1;
      pon_r <= 1'b0;
      clr_r <= '0;
      used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ml_r <= ml_nxt;
      scope_r <= scope_nxt;
      style_r <= style_nxt;
      pon_r <= pon_nxt;
      clr_r <= clr_nxt;
      used_r <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r <= in_tuser;
      ch_r <= in_tdata[8:0];
      lv_r <= in_tdata[16:9];
      force_r <= in_tdata[17];
      chtp_r <= in_tdata[18];
      cint_r <= in_tdata[19];
      ok_r <= in_ok;
    end
    if (cmd.prod) begin
      prod_r <= {8'd0, rd_e.base} * {8'd0, lv_r};
    end
    if (cmd.upd) begin
      v_r <= v;
      pt_r <= new_e.pt;
      cover_r <= (v != 8'd0) && (scope_r || new_e.flags[1]);
      acc_r <= ok_r && !rej;
    end
    if (cmd.scl) begin
      mprod_r <= {8'd0, v_r} * {8'd0, ml_r} + 16'd127;
    end
    if (cmd.fin) begin
      out_r <= {4'd0, used_r, acc_r, u, ch_r};
    end
  end

  assign out_tdata = out_r;
  assign out_tvalid = out_valid_r;
endmodule
`default_nettype wire

// ===== hdl/dmx_ctrl.sv =====
// controller: clearing pass and per-item sequence
`default_nettype none
`include "dmx_channel_merge_engine_defines.svh"
module dmx_ctrl import dmx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PRD  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_SCL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.prod = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = S_SCL;
      end
      S_SCL: begin
        cmd.scl = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `DMX_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
  `DMX_ASSERT_NOW(a_fin_free, clk, rst_n, cmd.fin, sts.out_free)
  `DMX_ASSERT_NEXT(a_take_seq, clk, rst_n, cmd.take, cmd.prod)
  `DMX_ASSERT_NEXT(a_upd_seq, clk, rst_n, cmd.upd, cmd.scl)
endmodule
`default_nettype wire

// ===== hdl/dmx_channel_merge_engine.sv =====
// top level of the dmx channel merge engine
// use: one dmx universe, each channel keeps base level, relative offset,
// htp / intensity flags and a passthrough level in one row of a ram
// in channel: in_tuser holds the op, in_tdata the channel and its operands;
// every item gives exactly one result item on the out channel
// cfg channel: cfg_index selects master_level (0), master_scope (1),
// master_style (2) or passthrough_on (3); cfg_ready is always high, write
// only while no item is in flight
// sequence: an accepted item runs through the read, multiply, update,
// master multiply and output steps in turn; a new item is accepted only
// once the previous one has left the output step
// reset: a clearing pass zeroes all CHANNELS rows, one per cycle, so
// in_tready stays low until the clearing pass has ended
// stall: the result waits in the output register; the next item is still
// accepted and worked up to the final step, which waits for the register
`default_nettype none
module dmx_channel_merge_engine import dmx_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // channel[8:0] level_in[16:9] force_latest[17]
                                      // cap_htp[18] cap_intensity[19] zero[23:20]
  input  wire logic [3:0]  in_tuser,  // op[3:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata, // channel_out[8:0] output_level[16:9]
                                      // accepted[17] used_count[27:18] zero[31:28]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dmx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  dmx_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready)
  );
endmodule
`default_nettype wire
